// ----- rtl/core/stereo_blob_distance_core_assert.svh -----
// Assertion macros shared by the stereo blob distance RTL.
`ifndef STEREO_BLOB_DISTANCE_CORE_ASSERT_SVH
`define STEREO_BLOB_DISTANCE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SBD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sbd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sbd assertion failed");

`endif

// ----- rtl/core/sbd_pkg.sv -----
// Types, constants and tables shared by the stereo blob distance core.
`default_nettype none
package sbd_pkg;

  localparam int unsigned PixXW    = 9;
  localparam int unsigned PixYW    = 8;
  localparam int unsigned RangeW   = 18;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgBaseline   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgElevOffset = 1'b1;

  localparam logic [RangeW-1:0] RangeMax = 18'h3ffff;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned Lanes       = 4;
  localparam int unsigned LaneA       = 0;
  localparam int unsigned LaneB       = 1;
  localparam int unsigned LaneC       = 2;
  localparam int unsigned LaneE       = 3;
  localparam int unsigned ZW          = 26;
  localparam int unsigned XW          = 32;

  localparam logic signed [XW-1:0] CordicK  = 32'sd652032874;
  localparam logic signed [ZW-1:0] DegQuart = 26'sd5898240;
  localparam logic signed [ZW-1:0] DegHalf  = 26'sd11796480;

  localparam int unsigned DivSteps  = 26;
  localparam int unsigned NumW      = 47;
  localparam int unsigned DenW      = 31;
  localparam int unsigned SqrtSteps = 28;
  localparam int unsigned SqW       = 56;
  localparam int unsigned CosW      = 18;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } cordic_lane_t;

  typedef cordic_lane_t [Lanes-1:0] cordic_vec_t;

  typedef struct packed {
    logic [NumW-1:0]     rem;
    logic [DenW-1:0]     den;
    logic [DivSteps-1:0] quo;
  } div_data_t;

  typedef struct packed {
    logic                   found;
    logic                   sat;
    logic                   neg;
    logic signed [CosW-1:0] cos16;
    logic signed [XW-1:0]   ce;
  } div_tag_t;

  typedef struct packed {
    logic [SqW-1:0] v;
    logic [SqW-1:0] root;
  } sqrt_data_t;

  typedef struct packed {
    logic                 found;
    logic                 sat;
    logic signed [XW-1:0] ce;
  } sqrt_tag_t;

  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
    logic signed [ZW-1:0] a;
    unique case (idx)
      0:  a = 26'sd2949120;
      1:  a = 26'sd1740967;
      2:  a = 26'sd919879;
      3:  a = 26'sd466945;
      4:  a = 26'sd234379;
      5:  a = 26'sd117266;
      6:  a = 26'sd58666;
      7:  a = 26'sd29335;
      8:  a = 26'sd14668;
      9:  a = 26'sd7334;
      10: a = 26'sd3667;
      11: a = 26'sd1833;
      12: a = 26'sd917;
      13: a = 26'sd458;
      14: a = 26'sd229;
      15: a = 26'sd115;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/sbd_stream_if.sv -----
// Valid/ready channel interfaces for blob pairs and range results.
`default_nettype none
interface sbd_in_if;
  import sbd_pkg::*;
  logic             valid;
  logic             ready;
  logic [PixXW-1:0] left_x;
  logic [PixYW-1:0] left_y;
  logic             left_found;
  logic [PixXW-1:0] right_x;
  logic [PixYW-1:0] right_y;
  logic             right_found;

  modport source (output valid, left_x, left_y, left_found, right_x, right_y, right_found,
                  input ready);
  modport sink (input valid, left_x, left_y, left_found, right_x, right_y, right_found,
                output ready);
endinterface

interface sbd_out_if;
  import sbd_pkg::*;
  logic              valid;
  logic              ready;
  logic              found;
  logic [RangeW-1:0] range_q8;
  logic              saturated;

  modport source (output valid, found, range_q8, saturated, input ready);
  modport sink (input valid, found, range_q8, saturated, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sbd_cordic_cell.sv -----
// One CORDIC rotation step applied to four angle lanes.
`default_nettype none
module sbd_cordic_cell #(
  parameter int unsigned Step = 0,
  parameter int unsigned TagW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [TagW-1:0]     tag_i,
  input  sbd_pkg::cordic_vec_t lane_i,
  output logic                valid_o,
  output logic [TagW-1:0]     tag_o,
  output sbd_pkg::cordic_vec_t lane_o
);
  import sbd_pkg::*;

  localparam logic signed [ZW-1:0] Angle = atan_q16(Step);

  logic            valid_q;
  logic [TagW-1:0] tag_q;
  cordic_vec_t     lane_d, lane_q;

  always_comb begin
    lane_d = lane_i;
    for (int k = 0; k < Lanes; k++) begin
      if (lane_i[k].z >= 0) begin
        lane_d[k].x = lane_i[k].x - (lane_i[k].y >>> Step);
        lane_d[k].y = lane_i[k].y + (lane_i[k].x >>> Step);
        lane_d[k].z = lane_i[k].z - Angle;
      end else begin
        lane_d[k].x = lane_i[k].x + (lane_i[k].y >>> Step);
        lane_d[k].y = lane_i[k].y - (lane_i[k].x >>> Step);
        lane_d[k].z = lane_i[k].z + Angle;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q  <= tag_i;
      lane_q <= lane_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign lane_o  = lane_q;
endmodule
`default_nettype wire

// ----- rtl/core/sbd_div_cell.sv -----
// One restoring division step: settles one quotient bit.
`default_nettype none
module sbd_div_cell #(
  parameter int unsigned Bit  = 0,
  parameter int unsigned TagW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [TagW-1:0]    tag_i,
  input  sbd_pkg::div_data_t data_i,
  output logic               valid_o,
  output logic [TagW-1:0]    tag_o,
  output sbd_pkg::div_data_t data_o
);
  import sbd_pkg::*;

  localparam int unsigned WideW = DenW + DivSteps;

  logic [WideW-1:0] dsh, rem_w;
  logic             valid_q;
  logic [TagW-1:0]  tag_q;
  div_data_t        data_d, data_q;

  assign dsh   = WideW'(data_i.den) << Bit;
  assign rem_w = WideW'(data_i.rem);

  always_comb begin
    data_d = data_i;
    if (rem_w >= dsh) begin
      data_d.rem      = data_i.rem - dsh[NumW-1:0];
      data_d.quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q  <= tag_i;
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

// ----- rtl/core/sbd_sqrt_cell.sv -----
// One digit-by-digit integer square root step.
`default_nettype none
module sbd_sqrt_cell #(
  parameter int unsigned Step = 0,
  parameter int unsigned TagW = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [TagW-1:0]     tag_i,
  input  sbd_pkg::sqrt_data_t data_i,
  output logic                valid_o,
  output logic [TagW-1:0]     tag_o,
  output sbd_pkg::sqrt_data_t data_o
);
  import sbd_pkg::*;

  localparam logic [SqW-1:0] Bit = {{(SqW-1){1'b0}}, 1'b1} << (2 * Step);

  logic [SqW-1:0]  trial;
  logic            valid_q;
  logic [TagW-1:0] tag_q;
  sqrt_data_t      data_d, data_q;

  assign trial = data_i.root + Bit;

  always_comb begin
    data_d = data_i;
    if (data_i.v >= trial) begin
      data_d.v    = data_i.v - trial;
      data_d.root = (data_i.root >> 1) + Bit;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q  <= tag_i;
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

// ----- rtl/core/stereo_blob_distance_core.sv -----
// Top level: stereo blob pair to level-ground range, fully pipelined cell chain.
// The chain holds 16 CORDIC, 26 divider and 28 root cells in line.
// Throughput: one transaction per cycle, except while the chain stalls.
// The whole chain stalls only while a finished result waits on the output register.
// Reset (rst_ni low, async): all valid bits clear, baseline 3200, elevation offset 0.
`default_nettype none
`include "stereo_blob_distance_core_assert.svh"
module stereo_blob_distance_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  sbd_in_if.sink                        item_i,
  sbd_out_if.source                     result_o,
  input  logic                          cfg_we_i,
  input  logic [sbd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sbd_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import sbd_pkg::*;

  localparam int unsigned DivTagW  = $bits(div_tag_t);
  localparam int unsigned SqrtTagW = $bits(sqrt_tag_t);

  function automatic logic [8:0] div316(input logic [16:0] t);
    logic [40:0] p;
    p = 41'(t) * 41'd13591669;
    return p[40:32];
  endfunction

  function automatic cordic_lane_t lane_init(input logic signed [ZW-1:0] z);
    cordic_lane_t l;
    l.x    = CordicK;
    l.y    = '0;
    l.z    = z;
    l.flip = 1'b0;
    if (z > DegQuart) begin
      l.z    = z - DegHalf;
      l.flip = 1'b1;
    end else if (z < -DegQuart) begin
      l.z    = z + DegHalf;
      l.flip = 1'b1;
    end
    return l;
  endfunction

  logic [15:0] baseline_q, elev_off_q;
  logic        adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= 16'd3200;
      elev_off_q <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgBaseline:   baseline_q <= cfg_wdata_i;
        CfgElevOffset: elev_off_q <= cfg_wdata_i;
      endcase
    end
  end

  logic out_valid_q;
  assign adv          = !out_valid_q || result_o.ready;
  assign item_i.ready = adv;

  // pixel offsets split into whole and remainder parts of the /316 scaling
  logic signed [9:0]  d_l, d_r;
  logic signed [10:0] dy;
  logic [8:0]         m_l, m_r, m_e;
  logic               s1_valid_q, s1_found_q, s1_neg_l_q, s1_neg_r_q, s1_neg_e_q;
  logic [22:0]        s1_b_l_q, s1_b_r_q, s1_b_e_q;
  logic [16:0]        s1_t_l_q, s1_t_r_q, s1_t_e_q;

  assign d_l = $signed({1'b0, item_i.left_x}) - 10'sd158;
  assign d_r = $signed({1'b0, item_i.right_x}) - 10'sd158;
  assign dy  = $signed({3'b0, item_i.left_y}) + $signed({3'b0, item_i.right_y}) - 11'sd212;
  assign m_l = d_l[9] ? 9'(-d_l) : 9'(d_l);
  assign m_r = d_r[9] ? 9'(-d_r) : 9'(d_r);
  assign m_e = dy[10] ? 9'(-dy) : 9'(dy);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_found_q <= item_i.left_found & item_i.right_found;
      s1_neg_l_q <= d_l[9];
      s1_neg_r_q <= d_r[9];
      s1_neg_e_q <= (dy > 11'sd0);
      s1_b_l_q   <= 23'(m_l) * 23'd12650;
      s1_b_r_q   <= 23'(m_r) * 23'd12650;
      s1_b_e_q   <= 23'(m_e) * 23'd6325;
      s1_t_l_q   <= 17'(m_l) * 17'd296 + 17'd158;
      s1_t_r_q   <= 17'(m_r) * 17'd296 + 17'd158;
      s1_t_e_q   <= (17'(m_e) * 17'd296 + 17'd316) >> 1;
    end
  end

  logic [22:0]          mag_l, mag_r, mag_e;
  logic                 s2_valid_q, s2_found_q;
  logic signed [ZW-1:0] s2_ang_l_q, s2_ang_r_q, s2_ang_e_q;

  assign mag_l = s1_b_l_q + 23'(div316(s1_t_l_q));
  assign mag_r = s1_b_r_q + 23'(div316(s1_t_r_q));
  assign mag_e = s1_b_e_q + 23'(div316(s1_t_e_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_found_q <= s1_found_q;
      s2_ang_l_q <= s1_neg_l_q ? -$signed(ZW'(mag_l)) : $signed(ZW'(mag_l));
      s2_ang_r_q <= s1_neg_r_q ? -$signed(ZW'(mag_r)) : $signed(ZW'(mag_r));
      s2_ang_e_q <= s1_neg_e_q ? -$signed(ZW'(mag_e)) : $signed(ZW'(mag_e));
    end
  end

  // triangle and elevation angles, folded into the CORDIC range
  logic signed [ZW-1:0] off_ext;
  cordic_vec_t          lane_start;
  logic [CordicSteps:0] cv_valid;
  logic [CordicSteps:0] cv_found;
  cordic_vec_t          cv_lane [CordicSteps+1];

  assign off_ext = ZW'($signed(elev_off_q));

  always_comb begin
    lane_start[LaneA] = lane_init(DegQuart - s2_ang_l_q);
    lane_start[LaneB] = lane_init(DegQuart + s2_ang_r_q);
    lane_start[LaneC] = lane_init(s2_ang_l_q - s2_ang_r_q);
    lane_start[LaneE] = lane_init(s2_ang_e_q + (off_ext <<< 8));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_valid[0] <= 1'b0;
    end else if (adv) begin
      cv_valid[0] <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cv_found[0] <= s2_found_q;
      cv_lane[0]  <= lane_start;
    end
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    sbd_cordic_cell #(.Step(i), .TagW(1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cv_valid[i]),
      .tag_i   (cv_found[i]),
      .lane_i  (cv_lane[i]),
      .valid_o (cv_valid[i+1]),
      .tag_o   (cv_found[i+1]),
      .lane_o  (cv_lane[i+1])
    );
  end

  // sines and cosines out; numerator of the law of sines
  cordic_lane_t         la, lb, lc, le;
  logic signed [XW-1:0] sb, sc, ca, ce;
  logic [XW-1:0]        sb_mag;
  logic                 s4_valid_q, s4_found_q, s4_neg_q, s4_bad_q;
  logic [NumW-1:0]      s4_num_q;
  logic [DenW-1:0]      s4_den_q;
  logic signed [CosW-1:0] s4_cos16_q;
  logic signed [XW-1:0] s4_ce_q;

  assign la     = cv_lane[CordicSteps][LaneA];
  assign lb     = cv_lane[CordicSteps][LaneB];
  assign lc     = cv_lane[CordicSteps][LaneC];
  assign le     = cv_lane[CordicSteps][LaneE];
  assign sb     = lb.flip ? -lb.y : lb.y;
  assign sc     = lc.flip ? -lc.y : lc.y;
  assign ca     = la.flip ? -la.x : la.x;
  assign ce     = le.flip ? -le.x : le.x;
  assign sb_mag = sb[XW-1] ? XW'(-sb) : XW'(sb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s4_valid_q <= cv_valid[CordicSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_found_q <= cv_found[CordicSteps];
      s4_neg_q   <= sb[XW-1];
      s4_bad_q   <= (sc <= 0);
      s4_num_q   <= NumW'(baseline_q) * NumW'(sb_mag[DenW-1:0]);
      s4_den_q   <= sc[DenW-1:0];
      s4_cos16_q <= CosW'(ca >>> 14);
      s4_ce_q    <= ce;
    end
  end

  logic [DivSteps:0]        dv_valid;
  div_tag_t                 dv_tag  [DivSteps+1];
  div_data_t                dv_data [DivSteps+1];
  logic                     ovf;

  assign ovf = {{(DenW + DivSteps - NumW){1'b0}}, s4_num_q} >= {s4_den_q, {DivSteps{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_valid[0] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_tag[0].found  <= s4_found_q;
      dv_tag[0].sat    <= s4_bad_q | ovf;
      dv_tag[0].neg    <= s4_neg_q;
      dv_tag[0].cos16  <= s4_cos16_q;
      dv_tag[0].ce     <= s4_ce_q;
      dv_data[0].rem   <= s4_num_q;
      dv_data[0].den   <= s4_den_q;
      dv_data[0].quo   <= '0;
    end
  end

  for (genvar j = 0; j < DivSteps; j++) begin : g_div
    sbd_div_cell #(.Bit(DivSteps - 1 - j), .TagW(DivTagW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (dv_valid[j]),
      .tag_i   (dv_tag[j]),
      .data_i  (dv_data[j]),
      .valid_o (dv_valid[j+1]),
      .tag_o   (dv_tag[j+1]),
      .data_o  (dv_data[j+1])
    );
  end

  // law of cosines terms
  div_tag_t                dt;
  logic [DivSteps-1:0]     quo;
  logic signed [DivSteps:0] side;
  logic                    s6_valid_q, s6_found_q, s6_sat_q;
  logic signed [XW-1:0]    s6_ce_q;
  logic signed [44:0]      s6_p1_q;
  logic [51:0]             s6_ssq_q;

  assign dt   = dv_tag[DivSteps];
  assign quo  = dv_data[DivSteps].quo;
  assign side = dt.neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (adv) begin
      s6_valid_q <= dv_valid[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_found_q <= dt.found;
      s6_sat_q   <= dt.sat;
      s6_ce_q    <= dt.ce;
      s6_p1_q    <= side * dt.cos16;
      s6_ssq_q   <= 52'(quo) * 52'(quo);
    end
  end

  logic signed [22:0] p1_hi;
  logic signed [16:0] base_s;
  logic               s7_valid_q, s7_found_q, s7_sat_q;
  logic signed [XW-1:0] s7_ce_q;
  logic [37:0]        s7_pp_lo_q;
  logic signed [39:0] s7_pp_hi_q;
  logic [51:0]        s7_ssq_q;
  logic [31:0]        s7_base2_q;

  assign p1_hi  = s6_p1_q[44:22];
  assign base_s = $signed({1'b0, baseline_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (adv) begin
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_found_q <= s6_found_q;
      s7_sat_q   <= s6_sat_q;
      s7_ce_q    <= s6_ce_q;
      s7_pp_lo_q <= 38'(s6_p1_q[21:0]) * 38'(baseline_q);
      s7_pp_hi_q <= p1_hi * base_s;
      s7_ssq_q   <= s6_ssq_q;
      s7_base2_q <= 32'(baseline_q) * 32'(baseline_q);
    end
  end

  logic signed [61:0]  hi_ext, lo_ext, prod, term, sq;
  logic [SqrtSteps:0]  sv_valid;
  sqrt_tag_t           sv_tag  [SqrtSteps+1];
  sqrt_data_t          sv_data [SqrtSteps+1];

  assign hi_ext = 62'(s7_pp_hi_q);
  assign lo_ext = $signed({24'b0, s7_pp_lo_q});
  assign prod   = (hi_ext <<< 22) + lo_ext;
  assign term   = prod >>> 14;
  assign sq     = $signed({8'b0, s7_ssq_q, 2'b0}) + $signed({30'b0, s7_base2_q}) - term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_valid[0] <= 1'b0;
    end else if (adv) begin
      sv_valid[0] <= s7_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sv_tag[0].found  <= s7_found_q;
      sv_tag[0].sat    <= s7_sat_q;
      sv_tag[0].ce     <= s7_ce_q;
      sv_data[0].v     <= sq[61] ? '0 : sq[SqW-1:0];
      sv_data[0].root  <= '0;
    end
  end

  for (genvar j = 0; j < SqrtSteps; j++) begin : g_sqrt
    sbd_sqrt_cell #(.Step(SqrtSteps - 1 - j), .TagW(SqrtTagW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sv_valid[j]),
      .tag_i   (sv_tag[j]),
      .data_i  (sv_data[j]),
      .valid_o (sv_valid[j+1]),
      .tag_o   (sv_tag[j+1]),
      .data_o  (sv_data[j+1])
    );
  end

  // ground projection
  sqrt_tag_t          st;
  logic               s9_valid_q, s9_found_q, s9_sat_q;
  logic signed [60:0] s9_prod_q;

  assign st = sv_tag[SqrtSteps];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_valid_q <= 1'b0;
    end else if (adv) begin
      s9_valid_q <= sv_valid[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s9_found_q <= st.found;
      s9_sat_q   <= st.sat;
      s9_prod_q  <= $signed({1'b0, sv_data[SqrtSteps].root[SqrtSteps-1:0]}) * st.ce;
    end
  end

  logic signed [61:0] level;
  logic               found_d, sat_d;
  logic [RangeW-1:0]  range_d;
  logic               found_q, sat_q;
  logic [RangeW-1:0]  range_q;

  assign level = (62'(s9_prod_q) + 62'sd1073741824) >>> 31;

  always_comb begin
    found_d = s9_found_q;
    sat_d   = 1'b0;
    range_d = '0;
    if (!s9_found_q) begin
      found_d = 1'b0;
    end else if (s9_sat_q) begin
      sat_d   = 1'b1;
      range_d = RangeMax;
    end else if (level < 0) begin
      sat_d   = 1'b1;
    end else if (level > $signed({44'b0, RangeMax})) begin
      sat_d   = 1'b1;
      range_d = RangeMax;
    end else begin
      range_d = level[RangeW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s9_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      found_q <= found_d;
      sat_q   <= sat_d;
      range_q <= range_d;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.found     = found_q;
  assign result_o.range_q8  = range_q;
  assign result_o.saturated = sat_q;

  `SBD_ASSERT_IMPL(a_missing_clear, clk_i, rst_ni, result_o.valid && !result_o.found, result_o.range_q8 == '0 && !result_o.saturated)
  `SBD_ASSERT_IMPL(a_sat_at_limit, clk_i, rst_ni, result_o.valid && result_o.saturated, result_o.range_q8 == '0 || result_o.range_q8 == RangeMax)
  `SBD_ASSERT_NEXT(a_enter_chain, clk_i, rst_ni, item_i.valid && item_i.ready, s1_valid_q)
  `SBD_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, !adv, $stable(s9_valid_q) && $stable(cv_valid))
endmodule
`default_nettype wire

// ----- dv/stereo_blob_distance_core_test.sv -----
// Testbench for stereo_blob_distance_core: random blob pairs checked against a range predictor.
`default_nettype none
module stereo_blob_distance_core_test;
  import sbd_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Drain      = 120;

  typedef struct {
    logic [PixXW-1:0] lx;
    logic [PixYW-1:0] ly;
    logic             lf;
    logic [PixXW-1:0] rx;
    logic [PixYW-1:0] ry;
    logic             rf;
  } blob_pair_t;

  typedef struct {
    logic              found;
    logic [RangeW-1:0] range_q8;
    logic              sat;
  } range_t;

  class range_board;
    range_t           expected_q[$];
    logic [15:0]      baseline;
    logic [15:0]      elev_off;
    int               mismatches;
    longint           atan_tbl[16];

    function new();
      baseline   = 16'd3200;
      elev_off   = 16'd0;
      mismatches = 0;
      atan_tbl = '{2949120, 1740967, 919879, 466945, 234379, 117266, 58666, 29335,
                   14668, 7334, 3667, 1833, 917, 458, 229, 115};
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
      if (idx == CfgBaseline) baseline = val;
      else if (idx == CfgElevOffset) elev_off = val;
    endfunction

    function longint rdiv(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    function void rotate(longint ang, output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit flip;
      x = 652032874; y = 0; z = ang % (360 * 65536); flip = 0;
      if (z > 180 * 65536) z -= 360 * 65536;
      if (z <= -180 * 65536) z += 360 * 65536;
      if (z > 90 * 65536) begin
        z -= 180 * 65536; flip = 1;
      end else if (z < -90 * 65536) begin
        z += 180 * 65536; flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_tbl[i];
        end else begin
          x += dx; y -= dy; z += atan_tbl[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      s = y; c = x;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function range_t predict(blob_pair_t p);
      range_t e;
      longint base, off, lang, rang, sa, ca, sb, cb, sc, cc, se, ce;
      longint side, sq, cos16, plane, level, dy;
      e = '{found: 1'b0, range_q8: '0, sat: 1'b0};
      if (!p.lf || !p.rf) return e;
      e.found = 1'b1;
      base = longint'(baseline);
      off = longint'(signed'(elev_off));
      lang = rdiv((longint'(p.lx) - 158) * 61 * 65536, 316);
      rang = rdiv((longint'(p.rx) - 158) * 61 * 65536, 316);
      rotate(90 * 65536 - lang, sa, ca);
      rotate(90 * 65536 + rang, sb, cb);
      rotate(lang - rang, sc, cc);
      if (sc <= 0) begin
        e.range_q8 = RangeMax; e.sat = 1'b1;
        return e;
      end
      side = (base * sb) / sc;
      if (side >= 67108864 || side <= -67108864) begin
        e.range_q8 = RangeMax; e.sat = 1'b1;
        return e;
      end
      cos16 = ca >>> 14;
      sq = 4 * side * side + base * base - ((4 * side * base * cos16) >>> 16);
      if (sq < 0) sq = 0;
      plane = longint'(root(longint'(sq)));
      dy = longint'(p.ly) + longint'(p.ry) - 212;
      rotate(rdiv(-dy * 61 * 65536, 632) + off * 256, se, ce);
      level = (plane * ce + (64'sd1 <<< 30)) >>> 31;
      if (level < 0) begin
        e.range_q8 = '0; e.sat = 1'b1;
      end else if (level > 262143) begin
        e.range_q8 = RangeMax; e.sat = 1'b1;
      end else begin
        e.range_q8 = level[RangeW-1:0];
      end
      return e;
    endfunction

    function void note_item(blob_pair_t p);
      expected_q.push_back(predict(p));
    endfunction

    function void check_result(range_t got);
      range_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0b range=%0d sat=%0b",
                   got.found, got.range_q8, got.sat);
        return;
      end
      e = expected_q.pop_front();
      if (got.found !== e.found || got.range_q8 !== e.range_q8 || got.sat !== e.sat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp found=%0b range=%0d sat=%0b, got found=%0b range=%0d sat=%0b",
                   e.found, e.range_q8, e.sat, got.found, got.range_q8, got.sat);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  int unsigned         cycles;
  int unsigned         out_stall;
  range_board          board = new();

  sbd_in_if  item_if ();
  sbd_out_if result_if ();

  stereo_blob_distance_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_if.sink),
    .result_o   (result_if.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_ni) begin
      if (result_if.valid && result_if.ready)
        board.check_result('{found: result_if.found, range_q8: result_if.range_q8,
                             sat: result_if.saturated});
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        result_if.ready <= 1'b0;
      end else begin
        out_stall <= pick_gap();
        result_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_pair(blob_pair_t p);
    int unsigned gap;
    item_if.valid       <= 1'b1;
    item_if.left_x      <= p.lx;
    item_if.left_y      <= p.ly;
    item_if.left_found  <= p.lf;
    item_if.right_x     <= p.rx;
    item_if.right_y     <= p.ry;
    item_if.right_found <= p.rf;
    do @(posedge clk_i); while (!item_if.ready);
    board.note_item(p);
    gap = pick_gap();
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  function automatic blob_pair_t rand_pair();
    blob_pair_t p;
    int unsigned r;
    r = $urandom_range(0, 99);
    p.lf = 1'b1; p.rf = 1'b1;
    p.ly = PixYW'($urandom_range(0, 211));
    p.ry = PixYW'($urandom_range(0, 211));
    if (r < 72) begin
      p.rx = PixXW'($urandom_range(0, 314));
      p.lx = PixXW'($urandom_range(32'(p.rx) + 1, 315));
    end else begin
      p.lx = PixXW'($urandom()); p.rx = PixXW'($urandom());
      p.ly = PixYW'($urandom()); p.ry = PixYW'($urandom());
      if (r >= 86) begin
        p.lf = 1'($urandom()); p.rf = 1'($urandom());
      end
    end
    return p;
  endfunction

  initial begin
    blob_pair_t dir_q[$];
    logic [15:0] base_set[8];
    logic [15:0] off_set[8];
    cycles              = 0;
    out_stall           = 0;
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CfgBaseline;
    cfg_wdata           = '0;
    item_if.valid       = 1'b0;
    item_if.left_x      = '0;
    item_if.left_y      = '0;
    item_if.left_found  = 1'b0;
    item_if.right_x     = '0;
    item_if.right_y     = '0;
    item_if.right_found = 1'b0;
    result_if.ready     = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // missing blobs, parallel/diverging rays, edges of the image, out-of-range pixels
    dir_q = '{
      '{lx: 200, ly: 100, lf: 0, rx: 100, ry: 100, rf: 1},
      '{lx: 200, ly: 100, lf: 1, rx: 100, ry: 100, rf: 0},
      '{lx: 511, ly: 255, lf: 0, rx: 511, ry: 255, rf: 0},
      '{lx: 158, ly: 106, lf: 1, rx: 158, ry: 106, rf: 1},
      '{lx: 0, ly: 0, lf: 1, rx: 0, ry: 0, rf: 1},
      '{lx: 100, ly: 106, lf: 1, rx: 200, ry: 106, rf: 1},
      '{lx: 315, ly: 106, lf: 1, rx: 0, ry: 106, rf: 1},
      '{lx: 159, ly: 106, lf: 1, rx: 158, ry: 106, rf: 1},
      '{lx: 170, ly: 0, lf: 1, rx: 150, ry: 0, rf: 1},
      '{lx: 170, ly: 211, lf: 1, rx: 150, ry: 211, rf: 1},
      '{lx: 315, ly: 211, lf: 1, rx: 314, ry: 0, rf: 1},
      '{lx: 511, ly: 255, lf: 1, rx: 0, ry: 255, rf: 1},
      '{lx: 511, ly: 0, lf: 1, rx: 256, ry: 128, rf: 1},
      '{lx: 300, ly: 255, lf: 1, rx: 10, ry: 255, rf: 1},
      '{lx: 1, ly: 1, lf: 1, rx: 0, ry: 1, rf: 1},
      '{lx: 200, ly: 50, lf: 1, rx: 120, ry: 60, rf: 1}
    };
    foreach (dir_q[i]) send_pair(dir_q[i]);

    base_set = '{16'd3200, 16'd1, 16'd65535, 16'd0, 16'd65535, 16'd3200, 16'd512, 16'd40000};
    off_set  = '{16'd0, 16'hA600, 16'd23040, 16'h8000, 16'hA600, 16'h7FFF, 16'd0, 16'd0};
    base_set[6] = 16'($urandom());
    off_set[6]  = 16'($urandom());
    off_set[7]  = 16'($urandom_range(0, 46080) - 23040);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      write_reg(CfgBaseline, base_set[ph]);
      write_reg(CfgElevOffset, off_set[ph]);
      repeat (150) send_pair(rand_pair());
    end

    wait_idle();
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
